[hdl/serial_console_line_editor_macros.svh]
// ---------------------------------------------------------------------------
// serial console line editor assertion macros
// immediate-cause and next-cycle property checks on clk / rst_n
// ---------------------------------------------------------------------------
`ifndef SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH
`define SERIAL_CONSOLE_LINE_EDITOR_MACROS_SVH

// consequent holds in the same cycle
`define SCLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define SCLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/scle_pkg.sv]
// ---------------------------------------------------------------------------
// scle_pkg
// shared types and constants of the serial console line editor
// ---------------------------------------------------------------------------
package scle_pkg;

  localparam int OPCODE_W   = 1;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 9;
  localparam int COUNT_W    = 9;
  localparam int MLL_W      = 10;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [OPCODE_W-1:0] OP_RX   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'h7f;

  localparam logic [MLL_W-1:0] MLL_RESET = 10'd384;

  // register index taken from paddr[2]
  localparam logic REG_MAX_LINE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PK_ECHO,
    PK_BS,
    PK_EOL,
    PK_READ
  } pend_kind_t;

endpackage

[hdl/scle_if.sv]
// ---------------------------------------------------------------------------
// scle channel interfaces
// valid / ready channels for input items and result items
// ---------------------------------------------------------------------------
interface scle_in_if;
  logic                                valid;
  logic                                ready;
  logic [scle_pkg::OPCODE_W-1:0]       opcode;
  logic [scle_pkg::BYTE_W-1:0]         rx_byte;
  logic [scle_pkg::INDEX_W-1:0]        read_index;

  modport source (output valid, output opcode, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

interface scle_out_if;
  logic                                valid;
  logic                                ready;
  logic                                item_kind;
  logic [scle_pkg::BYTE_W-1:0]         data_byte;
  logic                                line_done;
  logic [scle_pkg::COUNT_W-1:0]        line_length;
  logic                                last;

  modport source (output valid, output item_kind, output data_byte, output line_done,
                  output line_length, output last, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input line_done,
                  input line_length, input last, output ready);
endinterface

[hdl/serial_console_line_editor.sv]
// ---------------------------------------------------------------------------
// serial_console_line_editor
// edits a console line from received bytes and produces the echo stream
//
// in_ch carries one item per transfer: a received byte (opcode rx) or a
// read of one line store entry (opcode read). out_ch carries results, one
// per transfer, the last one of an item flagged by last. a printable byte
// gives one echo, backspace/delete on a non-empty line gives three, cr/lf
// gives cr lf with line_done and the length, a read gives one stored byte.
// other control bytes and backspace on an empty line give nothing.
// the first result passes through the pending item and then the output
// register. the result stream moves one result per cycle while out_ch is not
// stalled, and an item with no results loads no pending item; a new item is
// taken in the cycle its predecessor's last result enters the output register.
// a stall on out_ch holds the output register and the pending item, and
// in_ch.ready drops until the pending item's last result moves.
// reset clears the count, pending and output valid and sets
// max_line_length to 384; line store contents are undefined until written.
// max_line_length sits at cfg byte address 0.
// ---------------------------------------------------------------------------
`include "serial_console_line_editor_macros.svh"

module serial_console_line_editor #(
  parameter int LINE_DEPTH = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scle_in_if.sink                        in_ch,
  scle_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [scle_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [scle_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [scle_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW    = $clog2(LINE_DEPTH + 1);
  localparam int CMPW  = (LW > scle_pkg::MLL_W) ? LW : scle_pkg::MLL_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(LINE_DEPTH);

  // configuration
  logic [scle_pkg::MLL_W-1:0] max_line_length_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == scle_pkg::REG_MAX_LINE_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == scle_pkg::REG_MAX_LINE_LENGTH) ?
                      scle_pkg::PDATA_W'(max_line_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_length_r <= scle_pkg::MLL_RESET;
    end else if (cfg_wr) begin
      max_line_length_r <= cfg_pwdata[scle_pkg::MLL_W-1:0];
    end
  end

  // state
  logic [scle_pkg::COUNT_W-1:0] char_count_r, char_count_nxt;
  logic [scle_pkg::BYTE_W-1:0]  mem [LINE_DEPTH];
  logic [scle_pkg::BYTE_W-1:0]  mem_rd_r;

  // pending item
  logic                         p_valid_r, p_valid_nxt;
  scle_pkg::pend_kind_t         p_kind_r, p_kind_nxt;
  logic [scle_pkg::BYTE_W-1:0]  p_byte_r, p_byte_nxt;
  logic [scle_pkg::COUNT_W-1:0] p_len_r, p_len_nxt;
  logic                         p_rdok_r, p_rdok_nxt;
  logic [1:0]                   p_seq_r, p_seq_nxt;

  // output register
  logic                         out_valid_r;
  logic                         out_item_kind_r;
  logic [scle_pkg::BYTE_W-1:0]  out_data_byte_r;
  logic                         out_line_done_r;
  logic [scle_pkg::COUNT_W-1:0] out_line_length_r;
  logic                         out_last_r;

  // input decode
  logic                         in_acc;
  logic [scle_pkg::BYTE_W-1:0]  c;
  logic                         is_bs, is_eol, is_ctl;
  logic                         cnt_in_store;
  logic                         idx_in_store;
  logic [CMPW-1:0]              cnt_inc, limit;
  logic                         wr_en;
  logic [scle_pkg::BYTE_W-1:0]  wr_data;
  logic                         rd_en;
  logic                         p_load;

  // result selection
  logic                         out_free;
  logic                         res_kind;
  logic [scle_pkg::BYTE_W-1:0]  res_byte;
  logic                         res_done;
  logic [scle_pkg::COUNT_W-1:0] res_len;
  logic                         res_last;
  logic                         p_move;

  assign c            = in_ch.rx_byte;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_bs        = (c == scle_pkg::BYTE_BS) || (c == scle_pkg::BYTE_DEL);
  assign is_eol       = (c == scle_pkg::BYTE_CR) || (c == scle_pkg::BYTE_LF);
  assign is_ctl       = (c < scle_pkg::BYTE_SPACE);
  assign cnt_in_store = CMPW'(char_count_r) < DEPTH_C;
  assign idx_in_store = CMPW'(in_ch.read_index) < DEPTH_C;
  assign cnt_inc      = CMPW'(char_count_r) + CMPW'(1);
  assign limit        = (CMPW'(max_line_length_r) > DEPTH_C) ? DEPTH_C :
                        CMPW'(max_line_length_r);

  assign out_free = !out_valid_r || out_ch.ready;
  assign p_move   = p_valid_r && out_free;
  assign in_ch.ready = !p_valid_r || (out_free && res_last);

  always_comb begin
    char_count_nxt = char_count_r;
    wr_en          = 1'b0;
    wr_data        = scle_pkg::BYTE_NUL;
    rd_en          = 1'b0;
    p_load         = 1'b0;
    p_kind_nxt     = p_kind_r;
    p_byte_nxt     = c;
    p_len_nxt      = char_count_r;
    p_rdok_nxt     = idx_in_store;
    if (in_acc) begin
      if (in_ch.opcode == scle_pkg::OP_READ) begin
        rd_en      = 1'b1;
        p_load     = 1'b1;
        p_kind_nxt = scle_pkg::PK_READ;
      end else if (is_bs) begin
        if (char_count_r != '0) begin
          char_count_nxt = char_count_r - scle_pkg::COUNT_W'(1);
          p_load         = 1'b1;
          p_kind_nxt     = scle_pkg::PK_BS;
        end
      end else if (is_eol) begin
        wr_en          = cnt_in_store;
        wr_data        = scle_pkg::BYTE_NUL;
        char_count_nxt = '0;
        p_load         = 1'b1;
        p_kind_nxt     = scle_pkg::PK_EOL;
      end else if (!is_ctl) begin
        wr_en          = cnt_in_store;
        wr_data        = c;
        char_count_nxt = (cnt_inc >= limit) ? '0 : cnt_inc[scle_pkg::COUNT_W-1:0];
        p_load         = 1'b1;
        p_kind_nxt     = scle_pkg::PK_ECHO;
      end
    end
  end

  always_comb begin
    res_kind = scle_pkg::KIND_ECHO;
    res_byte = p_byte_r;
    res_done = 1'b0;
    res_len  = '0;
    res_last = 1'b0;
    case (p_kind_r)
      scle_pkg::PK_ECHO: begin
        res_last = 1'b1;
      end
      scle_pkg::PK_BS: begin
        if (p_seq_r == 2'd1) begin
          res_byte = scle_pkg::BYTE_SPACE;
        end
        res_last = (p_seq_r == 2'd2);
      end
      scle_pkg::PK_EOL: begin
        if (p_seq_r == 2'd0) begin
          res_byte = scle_pkg::BYTE_CR;
        end else begin
          res_byte = scle_pkg::BYTE_LF;
          res_done = 1'b1;
          res_len  = p_len_r;
          res_last = 1'b1;
        end
      end
      scle_pkg::PK_READ: begin
        res_kind = scle_pkg::KIND_READ;
        res_byte = p_rdok_r ? mem_rd_r : scle_pkg::BYTE_NUL;
        res_last = 1'b1;
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_seq_nxt   = p_seq_r;
    if (p_move) begin
      if (res_last) begin
        p_valid_nxt = 1'b0;
      end else begin
        p_seq_nxt = p_seq_r + 2'd1;
      end
    end
    if (p_load) begin
      p_valid_nxt = 1'b1;
      p_seq_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
      p_valid_r    <= 1'b0;
      p_seq_r      <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      char_count_r <= char_count_nxt;
      p_valid_r    <= p_valid_nxt;
      p_seq_r      <= p_seq_nxt;
      if (out_free) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_kind_r <= p_kind_nxt;
      p_byte_r <= p_byte_nxt;
      p_len_r  <= p_len_nxt;
      p_rdok_r <= p_rdok_nxt;
    end
    if (out_free) begin
      out_item_kind_r   <= res_kind;
      out_data_byte_r   <= res_byte;
      out_line_done_r   <= res_done;
      out_line_length_r <= res_len;
      out_last_r        <= res_last;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(char_count_r)] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[AW'(in_ch.read_index)];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.item_kind   = out_item_kind_r;
  assign out_ch.data_byte   = out_data_byte_r;
  assign out_ch.line_done   = out_line_done_r;
  assign out_ch.line_length = out_line_length_r;
  assign out_ch.last        = out_last_r;

  `SCLE_ASSERT_SAME(a_done_on_lf, out_valid_r && out_line_done_r, out_last_r && out_data_byte_r == scle_pkg::BYTE_LF && out_item_kind_r == scle_pkg::KIND_ECHO, "line_done not on final lf echo")
  `SCLE_ASSERT_NEXT(a_eol_clears, in_acc && in_ch.opcode == scle_pkg::OP_RX && is_eol, char_count_r == '0 && p_valid_r && p_kind_r == scle_pkg::PK_EOL, "line end did not clear count")
  `SCLE_ASSERT_SAME(a_single_seq, p_valid_r && (p_kind_r == scle_pkg::PK_ECHO || p_kind_r == scle_pkg::PK_READ), p_seq_r == 2'd0, "single result item past first result")
  `SCLE_ASSERT_NEXT(a_read_pending, in_acc && in_ch.opcode == scle_pkg::OP_READ, p_valid_r && p_kind_r == scle_pkg::PK_READ && p_seq_r == 2'd0, "read transfer not pending")

endmodule
